### rtl/canny_pkg.sv
// ----------------------------------------------------------------------------
// canny_pkg
// Shared types, register codes and constants of the streaming edge detector.
// ----------------------------------------------------------------------------
package canny_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [7:0]      RST_HIGH_THR     = 8'd70;
    localparam logic [7:0]      RST_LOW_THR      = 8'd21;

    // tan 23 and tan 68 degrees in q16
    localparam int TAN23_Q16 = 27818;
    localparam int TAN68_Q16 = 162207;

    localparam logic [7:0] MAG_SAT    = 8'd255;
    localparam int         ROOT_STEPS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_HIGH_THR     = 3'd2,
        REG_LOW_THR      = 3'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEC_HORZ    = 2'd0,
        SEC_DIAG_UR = 2'd1,
        SEC_VERT    = 2'd2,
        SEC_DIAG_DR = 2'd3
    } sector_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PSHIFT,
        ST_GRAD,
        ST_SQ,
        ST_SUM,
        ST_ROOT,
        ST_GSHIFT,
        ST_NMS,
        ST_HYST
    } back_state_t;

    typedef struct packed {
        logic [FW_W-1:0] width;
        logic [FH_W-1:0] height;
        logic [7:0]      high_thr;
        logic [7:0]      low_thr;
    } canny_cfg_t;

    typedef struct packed {
        logic       restart;
        logic       flush;
        logic [7:0] pixel;
    } canny_item_t;

    typedef struct packed {
        logic [7:0] mag;
        sector_t    sector;
    } grad_t;

endpackage

### rtl/canny_queue.sv
// ----------------------------------------------------------------------------
// canny_queue
// Small first-in first-out queue between the classifying front and the back.
// ----------------------------------------------------------------------------
module canny_queue import canny_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  canny_item_t din,
    input  logic        pop,
    output canny_item_t dout,
    output logic        full,
    output logic        empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    canny_item_t         store_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg;
    logic [AW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/canny_front.sv
// ----------------------------------------------------------------------------
// canny_front
// Configuration registers and input classification: pixels, draining flushes
// and flushes that do nothing.
// ----------------------------------------------------------------------------
module canny_front import canny_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            pixel,
    input  logic                  flush_item,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output canny_cfg_t            cfg,
    output logic                  q_push,
    output canny_item_t           q_din,
    input  logic                  q_full
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RWF   = $clog2(MAX_HEIGHT + 1);
    localparam int FCW   = $clog2(3 * MAX_WIDTH + 4);

    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [7:0]      hi_reg;
    logic [7:0]      lo_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [RWF-1:0]   row_reg, row_next;
    logic             complete_reg, complete_next;
    logic             pend_reg, pend_next;
    logic [FCW-1:0]   flush_cnt_reg, flush_cnt_next;

    logic [FW_W-1:0]  eff_w;
    logic [FH_W-1:0]  eff_h;
    logic [COL_W-1:0] wm1;
    logic [RWF-1:0]   hm1;
    logic [FCW-1:0]   flush_lim;
    logic             accept;
    logic             restart;
    logic             step_ok;
    logic [COL_W-1:0] base_col;
    logic [RWF-1:0]   base_row;
    logic             cfg_wr;

    always_comb
    begin
        if (fw_reg < FW_W'(3))
            eff_w = FW_W'(3);
        else if (32'(fw_reg) > MAX_WIDTH)
            eff_w = FW_W'(MAX_WIDTH);
        else
            eff_w = fw_reg;
        if (fh_reg < FH_W'(3))
            eff_h = FH_W'(3);
        else if (32'(fh_reg) > MAX_HEIGHT)
            eff_h = FH_W'(MAX_HEIGHT);
        else
            eff_h = fh_reg;
    end

    assign cfg.width    = eff_w;
    assign cfg.height   = eff_h;
    assign cfg.high_thr = hi_reg;
    assign cfg.low_thr  = lo_reg;

    assign wm1       = COL_W'(eff_w - FW_W'(1));
    assign hm1       = RWF'(eff_h - FH_W'(1));
    // a three-row frame owes only its own pixels
    assign flush_lim = (eff_h == FH_W'(3)) ? FCW'(32'(eff_w) * 3)
                                           : FCW'(32'(eff_w) * 3 + 3);

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign restart  = !flush_item && (pend_reg || complete_reg);
    // a flush only steps the pipeline while results of a whole frame are still owed
    assign step_ok  = !flush_item || (complete_reg && (flush_cnt_reg < flush_lim));
    assign q_push   = accept && step_ok;
    assign q_din.restart = restart;
    assign q_din.flush   = flush_item;
    assign q_din.pixel   = flush_item ? 8'd0 : pixel;
    assign cfg_wr   = cfg_valid && cfg_ready;

    assign base_col = restart ? '0 : col_reg;
    assign base_row = restart ? '0 : row_reg;

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        complete_next  = complete_reg;
        pend_next      = pend_reg;
        flush_cnt_next = flush_cnt_reg;
        if (accept && !flush_item)
        begin
            col_next       = (base_col == wm1) ? '0 : base_col + 1'b1;
            row_next       = base_row + RWF'(base_col == wm1);
            complete_next  = (base_col == wm1) && (base_row == hm1);
            pend_next      = 1'b0;
            flush_cnt_next = restart ? '0 : flush_cnt_reg;
        end
        else if (q_push)
        begin
            flush_cnt_next = flush_cnt_reg + 1'b1;
        end
        if (cfg_wr && ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT)))
        begin
            pend_next      = 1'b1;
            complete_next  = 1'b0;
            flush_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= RST_FRAME_WIDTH;
            fh_reg        <= RST_FRAME_HEIGHT;
            hi_reg        <= RST_HIGH_THR;
            lo_reg        <= RST_LOW_THR;
            col_reg       <= '0;
            row_reg       <= '0;
            complete_reg  <= 1'b0;
            pend_reg      <= 1'b1;
            flush_cnt_reg <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            complete_reg  <= complete_next;
            pend_reg      <= pend_next;
            flush_cnt_reg <= flush_cnt_next;
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                    REG_HIGH_THR:     hi_reg <= cfg_data[7:0];
                    REG_LOW_THR:      lo_reg <= cfg_data[7:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

### rtl/canny_back.sv
// ----------------------------------------------------------------------------
// canny_back
// Stencil sequencer: sobel, magnitude and sector, non-maximum suppression and
// hysteresis over three line buffers, one queued item at a time.
// ----------------------------------------------------------------------------
module canny_back import canny_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  canny_cfg_t  cfg,
    input  logic        q_empty,
    input  canny_item_t q_dout,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        edge_res,
    output logic        frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 8) + 1;
    localparam int STP_W = $clog2(ROOT_STEPS);

    back_state_t state_reg, state_next;

    // control strobes
    logic mem_re, pix_we, grad_we, supp_we, emit, advance, out_free;

    canny_item_t item_reg;
    logic [COL_W-1:0]        col0_reg, c1_reg, c2_reg, c3_reg;
    logic signed [ROW_W-1:0] r1_reg, r2_reg, r3_reg;

    logic [7:0]  pwin_reg [0:2][0:2];
    grad_t       gwin_reg [0:2][0:2];
    logic [7:0]  swin_reg [0:2][0:2];

    logic [15:0] pix_lines_reg  [MAX_WIDTH];
    logic [19:0] grad_lines_reg [MAX_WIDTH];
    logic [15:0] supp_lines_reg [MAX_WIDTH];
    logic [15:0] pix_rd_reg;
    logic [19:0] grad_rd_reg;
    logic [15:0] supp_rd_reg;

    logic [9:0]  ax_reg, ay_reg;
    logic        gx_pos_reg, gy_pos_reg;
    sector_t     sector_reg;
    logic [19:0] sq_reg;
    logic        sat_reg;
    logic [15:0] rad_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  root_reg;
    logic [STP_W-1:0] step_reg;
    logic        out_valid_reg, edge_reg, fend_reg;

    logic [COL_W-1:0]        wm1;
    logic signed [ROW_W-1:0] hm1;
    logic border1, border2, border3;

    logic [9:0]        gl, gr, gt, gb;
    logic signed [10:0] gx, gy;
    logic [27:0]       lhs, p23, p68;
    sector_t           sector_c;
    logic [20:0]       sum_c;
    logic [10:0]       remx, trial;
    grad_t             gnew;
    logic [7:0]        na, nb, sval;
    logic              strong_n, edge_c;
    grad_t             grad_old, grad_new_row;

    function automatic logic is_border(input logic signed [ROW_W-1:0] r,
                                       input logic [COL_W-1:0] c,
                                       input logic signed [ROW_W-1:0] hlast,
                                       input logic [COL_W-1:0] wlast);
        return (r <= 0) || (c == '0) || (r >= hlast) || (c >= wlast);
    endfunction

    function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] c,
                                                 input logic [COL_W-1:0] wlast);
        return (c == wlast) ? '0 : c + 1'b1;
    endfunction

    assign wm1 = COL_W'(cfg.width - FW_W'(1));
    assign hm1 = $signed(ROW_W'(cfg.height) - ROW_W'(1));
    assign border1 = is_border(r1_reg, c1_reg, hm1, wm1);
    assign border2 = is_border(r2_reg, c2_reg, hm1, wm1);
    assign border3 = is_border(r3_reg, c3_reg, hm1, wm1);
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = ST_READ;
            ST_READ:   state_next = ST_PSHIFT;
            ST_PSHIFT: state_next = ST_GRAD;
            ST_GRAD:   state_next = ST_SQ;
            ST_SQ:     state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT:   if (step_reg == STP_W'(ROOT_STEPS - 1)) state_next = ST_GSHIFT;
            ST_GSHIFT: state_next = ST_NMS;
            ST_NMS:    state_next = ST_HYST;
            // a drain flush walks on past positions above the frame
            ST_HYST:
                if (advance)
                    state_next = (item_reg.flush && r3_reg[ROW_W-1]) ? ST_READ : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // strobes
    always_comb
    begin
        q_pop   = 1'b0;
        mem_re  = 1'b0;
        pix_we  = 1'b0;
        grad_we = 1'b0;
        supp_we = 1'b0;
        emit    = 1'b0;
        advance = 1'b0;
        case (state_reg)
            ST_IDLE:   q_pop   = !q_empty;
            ST_READ:   mem_re  = 1'b1;
            ST_PSHIFT: pix_we  = 1'b1;
            ST_GSHIFT: grad_we = 1'b1;
            ST_NMS:    supp_we = 1'b1;
            ST_HYST:
            begin
                // only positions inside the frame give a result
                emit    = !r3_reg[ROW_W-1] && out_free;
                advance = r3_reg[ROW_W-1] || out_free;
            end
            default:   ;
        endcase
    end

    // sobel on the pixel window
    always_comb
    begin
        gl = 10'(pwin_reg[0][0]) + (10'(pwin_reg[1][0]) << 1) + 10'(pwin_reg[2][0]);
        gr = 10'(pwin_reg[0][2]) + (10'(pwin_reg[1][2]) << 1) + 10'(pwin_reg[2][2]);
        gt = 10'(pwin_reg[0][0]) + (10'(pwin_reg[0][1]) << 1) + 10'(pwin_reg[0][2]);
        gb = 10'(pwin_reg[2][0]) + (10'(pwin_reg[2][1]) << 1) + 10'(pwin_reg[2][2]);
        gx = $signed({1'b0, gl}) - $signed({1'b0, gr});
        gy = $signed({1'b0, gt}) - $signed({1'b0, gb});
    end

    // direction sector from |gy| * 2^16 against the tangent products
    always_comb
    begin
        lhs = 28'({ay_reg, 16'b0});
        p23 = 28'(ax_reg) * 28'(TAN23_Q16);
        p68 = 28'(ax_reg) * 28'(TAN68_Q16);
        if ((ax_reg == '0) && (ay_reg == '0))
            sector_c = SEC_HORZ;
        else if (lhs < p23)
            sector_c = SEC_HORZ;
        else if (lhs < p68)
            sector_c = (gx_pos_reg == gy_pos_reg) ? SEC_DIAG_UR : SEC_DIAG_DR;
        else
            sector_c = SEC_VERT;
    end

    assign sum_c = 21'(sq_reg) + 21'(20'(ay_reg) * 20'(ay_reg));
    assign remx  = {rem_reg, rad_reg[15:14]};
    assign trial = {1'b0, root_reg, 2'b01};

    assign grad_old     = grad_rd_reg[19:10];
    assign grad_new_row = grad_rd_reg[9:0];

    always_comb
    begin
        gnew.mag    = border1 ? 8'd0 : (sat_reg ? MAG_SAT : root_reg);
        gnew.sector = border1 ? SEC_HORZ : sector_reg;
    end

    // neighbours across the centre gradient direction
    always_comb
    begin
        case (gwin_reg[1][1].sector)
            SEC_HORZ:
            begin
                na = gwin_reg[1][2].mag;
                nb = gwin_reg[1][0].mag;
            end
            SEC_DIAG_UR:
            begin
                na = gwin_reg[0][2].mag;
                nb = gwin_reg[2][0].mag;
            end
            SEC_VERT:
            begin
                na = gwin_reg[2][1].mag;
                nb = gwin_reg[0][1].mag;
            end
            default:
            begin
                na = gwin_reg[2][2].mag;
                nb = gwin_reg[0][0].mag;
            end
        endcase
        if (border2)
            sval = 8'd0;
        else if ((gwin_reg[1][1].mag >= na) && (gwin_reg[1][1].mag >= nb))
            sval = gwin_reg[1][1].mag;
        else
            sval = 8'd0;
    end

    // double threshold, weak pixels promoted by a strong neighbour
    always_comb
    begin
        strong_n = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!((i == 1) && (j == 1)) && (swin_reg[i][j] >= cfg.high_thr))
                    strong_n = 1'b1;
            end
        end
        if (border3)
            edge_c = 1'b0;
        else if (swin_reg[1][1] >= cfg.high_thr)
            edge_c = 1'b1;
        else if (swin_reg[1][1] < cfg.low_thr)
            edge_c = 1'b0;
        else
            edge_c = strong_n;
    end

    // line buffers: each column word holds the two rows above the newest one
    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_lines_reg[col0_reg] <= {pix_rd_reg[7:0], item_reg.pixel};
        if (mem_re)
            pix_rd_reg <= pix_lines_reg[col0_reg];
    end

    always_ff @(posedge clk)
    begin
        if (grad_we)
            grad_lines_reg[c1_reg] <= {grad_new_row, gnew};
        if (mem_re)
            grad_rd_reg <= grad_lines_reg[c1_reg];
    end

    always_ff @(posedge clk)
    begin
        if (supp_we)
            supp_lines_reg[c2_reg] <= {supp_rd_reg[7:0], sval};
        if (mem_re)
            supp_rd_reg <= supp_lines_reg[c2_reg];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_dout;
        if (pix_we)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pwin_reg[i][0] <= pwin_reg[i][1];
                pwin_reg[i][1] <= pwin_reg[i][2];
            end
            pwin_reg[0][2] <= pix_rd_reg[15:8];
            pwin_reg[1][2] <= pix_rd_reg[7:0];
            pwin_reg[2][2] <= item_reg.pixel;
        end
        if (state_reg == ST_GRAD)
        begin
            ax_reg     <= gx[10] ? 10'(-gx) : 10'(gx);
            ay_reg     <= gy[10] ? 10'(-gy) : 10'(gy);
            gx_pos_reg <= !gx[10] && (gx != '0);
            gy_pos_reg <= !gy[10] && (gy != '0);
        end
        if (state_reg == ST_SQ)
        begin
            sector_reg <= sector_c;
            sq_reg     <= 20'(ax_reg) * 20'(ax_reg);
        end
        if (state_reg == ST_SUM)
        begin
            sat_reg  <= |sum_c[20:16];
            rad_reg  <= sum_c[15:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == ST_ROOT)
        begin
            rad_reg <= {rad_reg[13:0], 2'b00};
            if (remx >= trial)
            begin
                rem_reg  <= 9'(remx - trial);
                root_reg <= {root_reg[6:0], 1'b1};
            end
            else
            begin
                rem_reg  <= 9'(remx);
                root_reg <= {root_reg[6:0], 1'b0};
            end
        end
        if (grad_we)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gwin_reg[i][0] <= gwin_reg[i][1];
                gwin_reg[i][1] <= gwin_reg[i][2];
            end
            gwin_reg[0][2] <= grad_old;
            gwin_reg[1][2] <= grad_new_row;
            gwin_reg[2][2] <= gnew;
        end
        if (supp_we)
        begin
            for (int i = 0; i < 3; i++)
            begin
                swin_reg[i][0] <= swin_reg[i][1];
                swin_reg[i][1] <= swin_reg[i][2];
            end
            swin_reg[0][2] <= supp_rd_reg[15:8];
            swin_reg[1][2] <= supp_rd_reg[7:0];
            swin_reg[2][2] <= sval;
        end
        if (emit)
        begin
            edge_reg <= edge_c;
            fend_reg <= (r3_reg == hm1) && (c3_reg == wm1);
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            col0_reg      <= '0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            c3_reg        <= '0;
            r1_reg        <= '0;
            r2_reg        <= '0;
            r3_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SUM)
                step_reg <= '0;
            else if (state_reg == ST_ROOT)
                step_reg <= step_reg + 1'b1;
            // stage centres start before the frame, one row and column apart
            if (q_pop && q_dout.restart)
            begin
                col0_reg <= '0;
                c1_reg   <= wm1;
                c2_reg   <= wm1 - COL_W'(1);
                c3_reg   <= wm1 - COL_W'(2);
                r1_reg   <= ROW_W'(-2);
                r2_reg   <= ROW_W'(-3);
                r3_reg   <= ROW_W'(-4);
            end
            else if (advance)
            begin
                col0_reg <= col_inc(col0_reg, wm1);
                c1_reg   <= col_inc(c1_reg, wm1);
                c2_reg   <= col_inc(c2_reg, wm1);
                c3_reg   <= col_inc(c3_reg, wm1);
                r1_reg   <= r1_reg + ROW_W'(c1_reg == wm1);
                r2_reg   <= r2_reg + ROW_W'(c2_reg == wm1);
                r3_reg   <= r3_reg + ROW_W'(c3_reg == wm1);
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign edge_res  = edge_reg;
    assign frame_end = fend_reg;

endmodule

### rtl/canny_edge_stream_top.sv
// ----------------------------------------------------------------------------
// canny_edge_stream_top
// Back: a queued item walks every state of the back sequencer, including the
// bit-serial square root, and waits while the output register is stalled; the
// back takes the next item only when it is through with the last one. The
// input side takes an item per cycle until the 4-entry queue fills. A result
// leaves 3*W+3 items after its pixel.
// Reset: registers go to 640, 480, 70, 21; counters and queue clear; the line
// buffers are not cleared and hold nothing that is read before rewritten.
// ----------------------------------------------------------------------------
module canny_edge_stream_top import canny_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            pixel,
    input  logic                  flush_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  edge_res,
    output logic                  frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    canny_cfg_t  cfg;
    canny_item_t q_din, q_dout;
    logic        q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    canny_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .flush_item (flush_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .q_push     (q_push),
        .q_din      (q_din),
        .q_full     (q_full)
    );

    canny_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    canny_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_dout    (q_dout),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .edge_res  (edge_res),
        .frame_end (frame_end)
    );

    // the front never writes a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("queue written while full");

    // the back never takes from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("queue read while empty");

    // a transfer into the queue while it is empty leaves it non-empty
    assert property (@(posedge clk) disable iff (!rst_n) (q_push && q_empty) |=> !q_empty)
        else $error("queue lost an item");

endmodule
